// File: rtl/dnsr_pkg.sv
// Shared types, constants and answer record table for the DNS redirect responder.
`default_nettype none
package dnsr_pkg;

	localparam int MAX_PACKET = 512;
	localparam int POS_W      = $clog2(MAX_PACKET + 1);
	localparam int ANSWER_LEN = 16;
	localparam int ANS_IDX_W  = $clog2(ANSWER_LEN);

	// Answer record bytes
	localparam logic [7:0] ANS_PTR_HI  = 8'hC0;
	localparam logic [7:0] ANS_PTR_LO  = 8'h0C;
	localparam logic [7:0] ANS_ONE     = 8'h01;
	localparam logic [7:0] ANS_TTL_LO  = 8'h3C;
	localparam logic [7:0] ANS_RDLEN   = 8'h04;

	// Answer record byte indexes
	localparam logic [ANS_IDX_W-1:0] AI_PTR_HI  = ANS_IDX_W'(0);
	localparam logic [ANS_IDX_W-1:0] AI_PTR_LO  = ANS_IDX_W'(1);
	localparam logic [ANS_IDX_W-1:0] AI_TYPE_LO = ANS_IDX_W'(3);
	localparam logic [ANS_IDX_W-1:0] AI_CLS_LO  = ANS_IDX_W'(5);
	localparam logic [ANS_IDX_W-1:0] AI_TTL_LO  = ANS_IDX_W'(9);
	localparam logic [ANS_IDX_W-1:0] AI_RDLEN   = ANS_IDX_W'(11);
	localparam logic [ANS_IDX_W-1:0] AI_ADDR0   = ANS_IDX_W'(12);
	localparam logic [ANS_IDX_W-1:0] AI_ADDR1   = ANS_IDX_W'(13);
	localparam logic [ANS_IDX_W-1:0] AI_ADDR2   = ANS_IDX_W'(14);
	localparam logic [ANS_IDX_W-1:0] AI_ADDR3   = ANS_IDX_W'(15);

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_last;
	} rx_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       tx_drop;
	} tx_t;

	// One parsed item handed to the output stage
	typedef struct packed {
		logic       emit;
		logic       answer;
		logic [7:0] data;
		logic       last;
		logic       drop;
	} res_t;

	function automatic logic [7:0] ans_byte(input logic [ANS_IDX_W-1:0] idx,
			input logic [31:0] addr);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			AI_PTR_HI:             b = ANS_PTR_HI;
			AI_PTR_LO:             b = ANS_PTR_LO;
			AI_TYPE_LO, AI_CLS_LO: b = ANS_ONE;
			AI_TTL_LO:             b = ANS_TTL_LO;
			AI_RDLEN:              b = ANS_RDLEN;
			AI_ADDR0:              b = addr[7:0];
			AI_ADDR1:              b = addr[15:8];
			AI_ADDR2:              b = addr[23:16];
			AI_ADDR3:              b = addr[31:24];
			default:               b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// File: rtl/dnsr_parse.sv
// Query parser: frame state registers and per-byte rewrite and check logic.
`default_nettype none
module dnsr_parse import dnsr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  wire rx_t  rx,
	output res_t      res
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LABLEN = 3'd1;
	localparam logic [2:0] PH_LABEL  = 3'd2;
	localparam logic [2:0] PH_TYPECL = 3'd3;
	localparam logic [2:0] PH_TRAIL  = 3'd4;
	localparam logic [2:0] PH_DISCRD = 3'd5;

	localparam logic [POS_W-1:0] POS_FLAGS_HI = POS_W'(2);
	localparam logic [POS_W-1:0] POS_FLAGS_LO = POS_W'(3);
	localparam logic [POS_W-1:0] POS_QD_HI    = POS_W'(4);
	localparam logic [POS_W-1:0] POS_QD_LO    = POS_W'(5);
	localparam logic [POS_W-1:0] POS_AN_HI    = POS_W'(6);
	localparam logic [POS_W-1:0] POS_AN_LO    = POS_W'(7);
	localparam logic [POS_W-1:0] POS_NS_HI    = POS_W'(8);
	localparam logic [POS_W-1:0] POS_NS_LO    = POS_W'(9);
	localparam logic [POS_W-1:0] POS_AR_HI    = POS_W'(10);
	localparam logic [POS_W-1:0] POS_AR_LO    = POS_W'(11);
	localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_PACKET);
	localparam logic [POS_W-1:0] POS_ANS_MAX  = POS_W'(MAX_PACKET - ANSWER_LEN - 1);

	localparam logic [7:0] FLAGS_HI   = 8'h81;
	localparam logic [7:0] FLAGS_LO   = 8'h80;
	localparam logic [7:0] LABEL_LIM  = 8'd64;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [2:0]       ph_q, ph_d;
	logic [5:0]       lab_q, lab_d;
	logic             qhi_q, qhi_d;
	logic             tc_q, tc_d;

	logic       fail, answer, emit, restart, tc_next;
	logic [7:0] b, ob;
	logic [1:0] idx;

	always_comb begin
		b       = rx.rx_byte;
		ob      = b;
		fail    = 1'b0;
		answer  = 1'b0;
		emit    = 1'b1;
		restart = 1'b0;
		idx     = lab_q[1:0];
		tc_next = tc_q && (b == {7'b0, idx[0]});
		pos_d   = pos_q;
		ph_d    = ph_q;
		lab_d   = lab_q;
		qhi_d   = qhi_q;
		tc_d    = tc_q;
		res     = '0;

		if (ph_q == PH_TRAIL || ph_q == PH_DISCRD) begin
			emit    = 1'b0;
			restart = rx.rx_last;
		end else begin
			if (pos_q >= POS_LIMIT) begin
				fail = 1'b1;
			end else begin
				case (ph_q)
					PH_HEADER: begin
						case (pos_q)
							POS_FLAGS_HI: begin
								fail = b[7];
								ob   = FLAGS_HI;
							end
							POS_FLAGS_LO: ob = FLAGS_LO;
							POS_QD_HI: qhi_d = (b != 8'h00);
							POS_QD_LO: fail = !qhi_q && (b == 8'h00);
							POS_AN_HI: ob = 8'h00;
							POS_AN_LO: ob = 8'h01;
							POS_NS_HI, POS_NS_LO, POS_AR_HI, POS_AR_LO: ob = 8'h00;
							default: ;
						endcase
						if (pos_q == POS_AR_LO)
							ph_d = PH_LABLEN;
					end
					PH_LABLEN: begin
						if (b >= LABEL_LIM) begin
							fail = 1'b1;
						end else if (b == 8'h00) begin
							ph_d  = PH_TYPECL;
							lab_d = '0;
						end else begin
							lab_d = b[5:0];
							ph_d  = PH_LABEL;
						end
					end
					PH_LABEL: begin
						lab_d = lab_q - 6'd1;
						if (lab_q == 6'd1)
							ph_d = PH_LABLEN;
					end
					PH_TYPECL: begin
						tc_d = tc_next;
						if (idx == 2'd3) begin
							if (!tc_next || pos_q > POS_ANS_MAX)
								fail = 1'b1;
							else
								answer = 1'b1;
						end else begin
							lab_d = {4'b0, idx + 2'd1};
						end
					end
					default: fail = 1'b1;
				endcase
			end

			if (answer) begin
				res.answer = 1'b1;
				res.data   = b;
				if (rx.rx_last) begin
					restart = 1'b1;
				end else begin
					ph_d  = PH_TRAIL;
					pos_d = pos_q + POS_W'(1);
				end
			end else if (fail || rx.rx_last) begin
				res.last = 1'b1;
				res.drop = 1'b1;
				if (rx.rx_last)
					restart = 1'b1;
				else
					ph_d = PH_DISCRD;
			end else begin
				res.data = ob;
				pos_d    = pos_q + POS_W'(1);
			end
		end
		res.emit = emit;

		if (restart) begin
			pos_d = '0;
			ph_d  = PH_HEADER;
			lab_d = '0;
			qhi_d = 1'b0;
			tc_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ph_q  <= PH_HEADER;
			lab_q <= '0;
			qhi_q <= 1'b0;
			tc_q  <= 1'b1;
		end else if (take) begin
			pos_q <= pos_d;
			ph_q  <= ph_d;
			lab_q <= lab_d;
			qhi_q <= qhi_d;
			tc_q  <= tc_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/dnsr_tx.sv
// Output register with the answer record burst sequencer.
`default_nettype none
module dnsr_tx import dnsr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire res_t        res,
	input  wire logic [31:0] addr,
	output logic             tx_valid,
	input  wire logic        tx_ready,
	output tx_t              tx
);

	logic                 valid_q, burst_q;
	logic [ANS_IDX_W-1:0] idx_q;
	tx_t                  data_q;
	logic                 load, advance;

	// Free when empty, or when the current byte leaves and no burst follows
	assign rx_ready = !valid_q || (tx_ready && !burst_q);
	assign load     = rx_valid && rx_ready && res.emit;
	assign advance  = valid_q && tx_ready && burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			burst_q <= res.answer;
			idx_q   <= '0;
		end else if (advance) begin
			burst_q <= (idx_q != AI_ADDR3);
			idx_q   <= idx_q + ANS_IDX_W'(1);
		end else if (valid_q && tx_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.tx_byte <= res.data;
			data_q.tx_last <= res.last;
			data_q.tx_drop <= res.drop;
		end else if (advance) begin
			data_q.tx_byte <= ans_byte(idx_q, addr);
			data_q.tx_last <= (idx_q == AI_ADDR3);
			data_q.tx_drop <= 1'b0;
		end
	end

	assign tx_valid = valid_q;
	assign tx       = data_q;

endmodule
`default_nettype wire

// File: rtl/dns_a_query_redirect_responder.sv
// Top level of the DNS A query redirect responder.
// Takes a DNS query payload one byte per transfer on rx and streams the reply on tx:
// header rewritten to a response, question echoed, and after the last qclass byte a
// 16-byte A record carrying redirect_address (least significant byte first). A bad or
// short query ends in a single byte with tx_drop and tx_last set; downstream discards the
// partial frame. Bytes after the reply or after a drop are consumed up to rx_last with
// no output. Query bytes are taken at one per cycle unless tx stalls; the byte that completes
// the question holds rx off while the output register sequences the answer record.
// Write cfg only while the block is idle; cfg_ready is always high.
`default_nettype none
module dns_a_query_redirect_responder import dnsr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire rx_t         rx,
	output logic             tx_valid,
	input  wire logic        tx_ready,
	output tx_t              tx,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] addr_q;
	res_t        res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			addr_q <= '0;
		else if (cfg_valid)
			addr_q <= cfg_data;
	end

	dnsr_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (rx_valid && rx_ready),
		.rx     (rx),
		.res    (res)
	);

	dnsr_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.res      (res),
		.addr     (addr_q),
		.tx_valid (tx_valid),
		.tx_ready (tx_ready),
		.tx       (tx)
	);

endmodule
`default_nettype wire

// File: tb/dns_reply_checker.sv
// Reply predictor and scoreboard for the DNS redirect responder testbench.
`timescale 1ns / 1ps
module dns_reply_checker import dnsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  rx_t         rx,
	input  logic        tx_valid,
	input  logic        tx_ready,
	input  tx_t         tx,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam int FLAGS_HI_POS   = 2;
	localparam int FLAGS_LO_POS   = 3;
	localparam int QD_HI_POS      = 4;
	localparam int QD_LO_POS      = 5;
	localparam int ANCOUNT_HI_POS = 6;
	localparam int ANCOUNT_LO_POS = 7;
	localparam int HDR_LAST_POS   = 11;
	localparam int LABEL_LIMIT    = 64;
	localparam logic [15:0] REPLY_FLAGS = 16'h8180;

	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_LABLEN,
		PARSE_LABEL,
		PARSE_QTAIL,
		PARSE_TRAIL,
		PARSE_DISCARD
	} parse_e;

	logic [31:0] redirect_addr = '0;
	int          frame_pos     = 0;
	parse_e      parse_phase   = PARSE_HEADER;
	logic [5:0]  label_left    = '0;
	logic        qd_hi_nonzero = 1'b0;
	logic        qtail_ok      = 1'b1;
	tx_t         expected_reply [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic void restart_frame();
		frame_pos     = 0;
		parse_phase   = PARSE_HEADER;
		label_left    = '0;
		qd_hi_nonzero = 1'b0;
		qtail_ok      = 1'b1;
	endfunction

	function automatic void push_reply(input logic [7:0] b, input logic eof, input logic drop);
		tx_t t;
		t.tx_byte = b;
		t.tx_last = eof;
		t.tx_drop = drop;
		expected_reply.push_back(t);
	endfunction

	task automatic predict_reply(input rx_t item);
		logic [7:0]                b;
		logic [7:0]                ob;
		logic                      eof;
		logic                      abort;
		logic [1:0]                qidx;
		int                        pos;
		logic [ANSWER_LEN*8-1:0]   record;
		b     = item.rx_byte;
		eof   = item.rx_last;
		ob    = b;
		abort = 1'b0;
		pos   = frame_pos;
		qidx  = label_left[1:0];

		// consume silently up to the end of the datagram
		if (parse_phase == PARSE_TRAIL || parse_phase == PARSE_DISCARD) begin
			if (eof)
				restart_frame();
			return;
		end

		if (pos >= MAX_PACKET) begin
			abort = 1'b1;
		end else begin
			case (parse_phase)
				PARSE_HEADER: begin
					case (pos)
						FLAGS_HI_POS: begin
							abort = b[7];
							ob = REPLY_FLAGS[15:8];
						end
						FLAGS_LO_POS:   ob = REPLY_FLAGS[7:0];
						QD_HI_POS:      qd_hi_nonzero = (b != 8'h00);
						QD_LO_POS:      abort = !qd_hi_nonzero && b == 8'h00;
						ANCOUNT_HI_POS: ob = 8'h00;
						ANCOUNT_LO_POS: ob = 8'h01;
						default: begin
							if (pos > ANCOUNT_LO_POS)
								ob = 8'h00;
						end
					endcase
					if (pos == HDR_LAST_POS)
						parse_phase = PARSE_LABLEN;
				end
				PARSE_LABLEN: begin
					if (b >= LABEL_LIMIT) begin
						abort = 1'b1;
					end else if (b == 8'h00) begin
						parse_phase = PARSE_QTAIL;
						label_left  = '0;
					end else begin
						label_left  = b[5:0];
						parse_phase = PARSE_LABEL;
					end
				end
				PARSE_LABEL: begin
					label_left = label_left - 6'd1;
					if (label_left == '0)
						parse_phase = PARSE_LABLEN;
				end
				default: begin
					// qtype and qclass must both read 0x0001
					if (b != {7'd0, qidx[0]})
						qtail_ok = 1'b0;
					if (qidx == 2'd3) begin
						if (!qtail_ok || pos + 1 + ANSWER_LEN > MAX_PACKET) begin
							abort = 1'b1;
						end else begin
							record = {ANS_PTR_HI, ANS_PTR_LO, 8'h00, ANS_ONE,
								8'h00, ANS_ONE, 8'h00, 8'h00, 8'h00, ANS_TTL_LO,
								8'h00, ANS_RDLEN, redirect_addr[7:0],
								redirect_addr[15:8], redirect_addr[23:16],
								redirect_addr[31:24]};
							push_reply(b, 1'b0, 1'b0);
							for (int k = 0; k < ANSWER_LEN; k++)
								push_reply(record[8*(ANSWER_LEN-1-k) +: 8],
									k == ANSWER_LEN - 1, 1'b0);
							if (eof) begin
								restart_frame();
							end else begin
								parse_phase = PARSE_TRAIL;
								frame_pos   = pos + 1;
							end
							return;
						end
					end else begin
						label_left = {4'd0, qidx} + 6'd1;
					end
				end
			endcase
		end

		if (abort || eof) begin
			push_reply(8'h00, 1'b1, 1'b1);
			if (eof)
				restart_frame();
			else
				parse_phase = PARSE_DISCARD;
			return;
		end

		push_reply(ob, 1'b0, 1'b0);
		if (frame_pos < MAX_PACKET)
			frame_pos = pos + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tx_t want;
		if (!arst_n) begin
			redirect_addr = '0;
			restart_frame();
			expected_reply.delete();
			pending = 0;
		end else begin
			// check outputs before predicting: a reply never leaves on its own input edge
			if (tx_valid && tx_ready) begin
				if (expected_reply.size() == 0) begin
					$display("%0t: unexpected tx transfer: expected none, got byte %02h last %0b drop %0b",
						$time, tx.tx_byte, tx.tx_last, tx.tx_drop);
					fail_count++;
				end else begin
					want = expected_reply.pop_front();
					if (tx.tx_byte !== want.tx_byte || tx.tx_last !== want.tx_last ||
							tx.tx_drop !== want.tx_drop) begin
						$display("%0t: tx mismatch: expected byte %02h last %0b drop %0b,",
							$time, want.tx_byte, want.tx_last, want.tx_drop);
						$display("%0t:   got byte %02h last %0b drop %0b",
							$time, tx.tx_byte, tx.tx_last, tx.tx_drop);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				redirect_addr = cfg_data;
			if (rx_valid && rx_ready)
				predict_reply(rx);
			pending = expected_reply.size();
		end
	end

endmodule

// File: tb/dns_a_query_redirect_responder_tb.sv
// Stimulus, clocking and verdict for the DNS redirect responder testbench.
`timescale 1ns / 1ps
module dns_a_query_redirect_responder_tb import dnsr_pkg::*;;

	localparam int          CYCLE_LIMIT   = 300000;
	localparam int          STALL_CYCLES  = 120;
	localparam int          SETTLE_CYCLES = 24;
	localparam int          PHASE_BYTES   = 110;
	localparam logic [31:0] QTAIL_A_IN    = 32'h0001_0001;
	localparam int          LABEL_MAX     = 63;

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_ready;
	rx_t         rx_item;
	logic        tx_valid;
	logic        tx_ready;
	tx_t         tx_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	int          fail_count;
	int          pending;
	int          cycle_count;
	int          bytes_sent;
	logic        quiet;
	logic        stall_req;
	logic [7:0]  query_bytes [$];

	// the cfg port carries the one register without an index
	dns_a_query_redirect_responder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx        (rx_item),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx        (tx_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dns_reply_checker u_reply_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx         (rx_item),
		.tx_valid   (tx_valid),
		.tx_ready   (tx_ready),
		.tx         (tx_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		tx_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				tx_ready <= 1'b0;
				repeat (STALL_CYCLES - 1) @(negedge clk);
				stall_req = 1'b0;
			end else begin
				tx_ready <= quiet || $urandom_range(0, 99) >= 8;
			end
		end
	end

	task automatic send_query_byte(input logic [7:0] b, input logic eof);
		if (!quiet && $urandom_range(0, 99) < 8) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_item  <= '{rx_byte: b, rx_last: eof};
		do @(posedge clk); while (!rx_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_datagram();
		for (int i = 0; i < query_bytes.size(); i++)
			send_query_byte(query_bytes[i], i == query_bytes.size() - 1);
		query_bytes.delete();
	endtask

	task automatic write_redirect(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain every expected reply, then give the parser time to finish silent bytes
	task automatic settle();
		rx_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_header(input logic [7:0] flags_hi, input logic [15:0] qdcount);
		query_bytes.push_back(8'($urandom));
		query_bytes.push_back(8'($urandom));
		query_bytes.push_back(flags_hi);
		query_bytes.push_back(8'($urandom));
		query_bytes.push_back(qdcount[15:8]);
		query_bytes.push_back(qdcount[7:0]);
		repeat (6) query_bytes.push_back(8'($urandom));
	endtask

	task automatic put_label(input int len);
		query_bytes.push_back(8'(len));
		repeat (len) query_bytes.push_back(8'($urandom));
	endtask

	task automatic put_qtail(input logic [31:0] qtail);
		for (int i = 3; i >= 0; i--)
			query_bytes.push_back(qtail[8*i +: 8]);
	endtask

	task automatic put_trailer(input int count);
		repeat (count) query_bytes.push_back(8'($urandom));
	endtask

	task automatic build_query();
		logic [15:0] qd;
		qd = $urandom_range(0, 1) ? 16'($urandom_range(1, 255)) : 16'($urandom_range(1, 65535));
		put_header({1'b0, 7'($urandom)}, qd);
		repeat ($urandom_range(0, 3))
			put_label($urandom_range(0, 9) == 0 ? LABEL_MAX : $urandom_range(1, 12));
		query_bytes.push_back(8'h00);
		put_qtail(QTAIL_A_IN);
	endtask

	task automatic build_random_datagram();
		int kind;
		int k;
		kind = $urandom_range(0, 99);
		if (kind < 94)
			build_query();
		if (kind < 65) begin
			if ($urandom_range(0, 9) < 3)
				put_trailer($urandom_range(1, 6));
		end else if (kind < 70) begin
			query_bytes[2] = query_bytes[2] | 8'h80;
		end else if (kind < 75) begin
			query_bytes[4] = 8'h00;
			query_bytes[5] = 8'h00;
		end else if (kind < 80) begin
			// replace the terminator and tail with an oversized length byte
			repeat (5) void'(query_bytes.pop_back());
			query_bytes.push_back(8'($urandom_range(LABEL_MAX + 1, 255)));
			put_trailer($urandom_range(0, 4));
		end else if (kind < 87) begin
			k = query_bytes.size() - 1 - $urandom_range(0, 3);
			query_bytes[k] = query_bytes[k] ^ 8'($urandom_range(1, 255));
		end else if (kind < 94) begin
			repeat ($urandom_range(1, query_bytes.size() - 1)) void'(query_bytes.pop_back());
		end else begin
			put_trailer($urandom_range(1, 30));
		end
	endtask

	initial begin
		int phase_start;
		arst_n     = 1'b0;
		rx_valid   = 1'b0;
		rx_item    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		quiet      = 1'b0;
		stall_req  = 1'b0;
		bytes_sent = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		write_redirect(32'hFFFF_FFFF);

		// root name, single question
		put_header(8'h01, 16'h0001);
		query_bytes.push_back(8'h00);
		put_qtail(QTAIL_A_IN);
		send_datagram();

		// question count with only the high byte set, trailing bytes after the answer
		put_header(8'h7F, 16'h0100);
		put_label(3);
		put_label(LABEL_MAX);
		query_bytes.push_back(8'h00);
		put_qtail(QTAIL_A_IN);
		put_trailer(5);
		send_datagram();

		// response bit set
		put_header(8'h80, 16'h0001);
		put_trailer(10);
		send_datagram();

		// zero question count
		put_header(8'h00, 16'h0000);
		put_trailer(6);
		send_datagram();

		// label length at the limit and beyond
		put_header(8'h00, 16'h0001);
		put_label(LABEL_MAX + 1);
		send_datagram();
		put_header(8'h00, 16'h0001);
		put_label(2);
		query_bytes.push_back(8'hFF);
		put_trailer(3);
		send_datagram();

		// wrong qtype, wrong qclass, type high byte set
		put_header(8'h00, 16'h0001);
		query_bytes.push_back(8'h00);
		put_qtail(32'h001C_0001);
		send_datagram();
		put_header(8'h00, 16'h0001);
		put_label(4);
		query_bytes.push_back(8'h00);
		put_qtail(32'h0001_00FF);
		put_trailer(2);
		send_datagram();
		put_header(8'h00, 16'h0001);
		query_bytes.push_back(8'h00);
		put_qtail(32'h0101_0001);
		send_datagram();

		settle();
		write_redirect(32'h0000_0000);

		// truncated datagrams: one byte, inside the header, inside a label, before last qclass
		query_bytes.push_back(8'hFF);
		send_datagram();
		put_header(8'h00, 16'h0001);
		repeat (6) void'(query_bytes.pop_back());
		send_datagram();
		put_header(8'h00, 16'h0001);
		put_label(8);
		repeat (3) void'(query_bytes.pop_back());
		send_datagram();
		put_header(8'h00, 16'h0001);
		query_bytes.push_back(8'h00);
		put_qtail(QTAIL_A_IN);
		void'(query_bytes.pop_back());
		send_datagram();

		// reply exactly at the size limit, trailing bytes run past it
		put_header(8'h00, 16'h0001);
		repeat (7) put_label(LABEL_MAX);
		put_label(30);
		query_bytes.push_back(8'h00);
		put_qtail(QTAIL_A_IN);
		put_trailer(30);
		send_datagram();

		// reply one byte over the size limit
		put_header(8'h00, 16'h0001);
		repeat (7) put_label(LABEL_MAX);
		put_label(31);
		query_bytes.push_back(8'h00);
		put_qtail(QTAIL_A_IN);
		send_datagram();

		// question runs past the input limit
		put_header(8'h00, 16'h0001);
		repeat (9) put_label(LABEL_MAX);
		send_datagram();

		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       write_redirect($urandom);
				1:       write_redirect(32'h8000_0001);
				default: write_redirect($urandom);
			endcase
			quiet = (phase == 0);
			if (phase == 1)
				stall_req = 1'b1;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				build_random_datagram();
				send_datagram();
			end
			settle();
		end
		quiet = 1'b0;

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
